### rtl/gpt_pkg.sv
// shared codes for the general purpose timer: operation codes, register
// selects and control register bit positions. no dependencies.
package gpt_pkg;

	// item operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// register selects
	localparam logic [2:0] REG_CR1  = 3'd0;
	localparam logic [2:0] REG_DIER = 3'd1;
	localparam logic [2:0] REG_SR   = 3'd2;
	localparam logic [2:0] REG_CNT  = 3'd3;
	localparam logic [2:0] REG_PSC  = 3'd4;
	localparam logic [2:0] REG_ARR  = 3'd5;

	// control register bit positions on the bus
	localparam int CR1_CEN  = 0;
	localparam int CR1_URS  = 2;
	localparam int CR1_OPM  = 3;
	localparam int CR1_DIR  = 4;
	localparam int CR1_CMS  = 5;
	localparam int CR1_ARPE = 7;

	localparam int BUS_W = 16;

	typedef logic [BUS_W-1:0] bus_word_t;

endpackage

### rtl/general_purpose_timer.sv
// general purpose up/down/centre-aligned timer with prescaler and auto-reload.
// depends on gpt_pkg for operation codes, register selects and bit positions.
// the result of an accepted item is registered in the output register on the next clock.
// throughput: one item (tick or bus access) per cycle; input is taken whenever
// the output register is empty or being drained in the same cycle.
// reset (arst_n low, asynchronous): control, enables, flag, counter and
// prescaler clear to zero, auto-reload and its shadow go to all ones.
module general_purpose_timer import gpt_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      operation,
	input  logic [2:0]      reg_select,
	input  logic [BUS_W-1:0] write_data,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [BUS_W-1:0] read_data,
	output logic            irq_level,
	output logic            update_event
);

	localparam int CMP_W = ((COUNT_WIDTH > BUS_W) ? COUNT_WIDTH : BUS_W) + 1;

	// control register fields
	logic cen_q, urs_q, opm_q, dir_q, arpe_q;
	logic [1:0] cms_q;
	logic [1:0] dier_q;
	logic uif_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	bus_word_t psc_q, psc_act_q, psc_cnt_q;
	bus_word_t arr_q, arr_act_q;
	logic phase_down_q;

	// next state
	logic cen_d, urs_d, opm_d, dir_d, arpe_d;
	logic [1:0] cms_d;
	logic [1:0] dier_d;
	logic uif_d;
	logic [COUNT_WIDTH-1:0] cnt_d;
	bus_word_t psc_d, psc_act_d, psc_cnt_d;
	bus_word_t arr_d, arr_act_d;
	logic phase_down_d;

	// output register
	logic out_valid_q;
	bus_word_t rd_q;
	logic irq_q, upd_q;

	bus_word_t rd_d;
	logic upd_d;

	logic accept;
	logic [CMP_W-1:0] cnt_ext, cnt_inc, arr_act_ext, arr_new_ext, wd_ext;
	logic cr1_dir_shown;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign cnt_ext     = CMP_W'(cnt_q);
	assign cnt_inc     = cnt_ext + CMP_W'(1);
	assign arr_act_ext = CMP_W'(arr_act_q);
	assign arr_new_ext = CMP_W'(arr_q);
	assign wd_ext      = CMP_W'(write_data);

	// in centre-aligned mode the direction bit reads back the current phase
	assign cr1_dir_shown = (cms_q != 2'b00) ? phase_down_q : dir_q;

	always_comb begin
		cen_d        = cen_q;
		urs_d        = urs_q;
		opm_d        = opm_q;
		dir_d        = dir_q;
		cms_d        = cms_q;
		arpe_d       = arpe_q;
		dier_d       = dier_q;
		uif_d        = uif_q;
		cnt_d        = cnt_q;
		psc_d        = psc_q;
		psc_act_d    = psc_act_q;
		psc_cnt_d    = psc_cnt_q;
		arr_d        = arr_q;
		arr_act_d    = arr_act_q;
		phase_down_d = phase_down_q;
		rd_d         = '0;
		upd_d        = 1'b0;

		unique case (operation)
			OP_TICK: begin
				if (cen_q) begin
					if (psc_cnt_q >= psc_act_q) begin
						psc_cnt_d = '0;
						if (arr_act_q != '0) begin
							if (cms_q != 2'b00) begin
								if (!phase_down_q) begin
									if (cnt_inc >= arr_act_ext) begin
										cnt_d        = arr_act_ext[COUNT_WIDTH-1:0];
										phase_down_d = 1'b1;
										upd_d        = 1'b1;
									end else begin
										cnt_d = cnt_inc[COUNT_WIDTH-1:0];
									end
								end else begin
									if (cnt_q <= COUNT_WIDTH'(1)) begin
										cnt_d        = '0;
										phase_down_d = 1'b0;
										upd_d        = 1'b1;
									end else begin
										cnt_d = cnt_q - COUNT_WIDTH'(1);
									end
								end
							end else if (dir_q) begin
								// underflow reloads from the freshly transferred value
								if (cnt_q == '0) begin
									cnt_d = arr_new_ext[COUNT_WIDTH-1:0];
									upd_d = 1'b1;
								end else begin
									cnt_d = cnt_q - COUNT_WIDTH'(1);
								end
							end else begin
								if (cnt_ext >= arr_act_ext) begin
									cnt_d = '0;
									upd_d = 1'b1;
								end else begin
									cnt_d = cnt_inc[COUNT_WIDTH-1:0];
								end
							end
						end
					end else begin
						psc_cnt_d = psc_cnt_q + BUS_W'(1);
					end
				end
				if (upd_d) begin
					uif_d     = 1'b1;
					psc_act_d = psc_q;
					arr_act_d = arr_q;
					if (opm_q)
						cen_d = 1'b0;
				end
			end
			OP_WRITE: begin
				unique case (reg_select)
					REG_CR1: begin
						cen_d  = write_data[CR1_CEN];
						urs_d  = write_data[CR1_URS];
						opm_d  = write_data[CR1_OPM];
						dir_d  = write_data[CR1_DIR];
						cms_d  = write_data[CR1_CMS +: 2];
						arpe_d = write_data[CR1_ARPE];
					end
					REG_DIER: dier_d = write_data[1:0];
					REG_SR:   uif_d  = uif_q & write_data[0];
					REG_CNT:  cnt_d  = wd_ext[COUNT_WIDTH-1:0];
					REG_PSC:  psc_d  = write_data;
					REG_ARR: begin
						arr_d = write_data;
						if (!arpe_q)
							arr_act_d = write_data;
					end
					default: ;
				endcase
			end
			OP_READ: begin
				unique case (reg_select)
					REG_CR1: begin
						rd_d[CR1_CEN]      = cen_q;
						rd_d[CR1_URS]      = urs_q;
						rd_d[CR1_OPM]      = opm_q;
						rd_d[CR1_DIR]      = cr1_dir_shown;
						rd_d[CR1_CMS +: 2] = cms_q;
						rd_d[CR1_ARPE]     = arpe_q;
					end
					REG_DIER: rd_d = BUS_W'(dier_q);
					REG_SR:   rd_d = BUS_W'(uif_q);
					REG_CNT:  rd_d = cnt_ext[BUS_W-1:0];
					REG_PSC:  rd_d = psc_q;
					REG_ARR:  rd_d = arr_q;
					default:  rd_d = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_q        <= 1'b0;
			urs_q        <= 1'b0;
			opm_q        <= 1'b0;
			dir_q        <= 1'b0;
			cms_q        <= 2'b00;
			arpe_q       <= 1'b0;
			dier_q       <= 2'b00;
			uif_q        <= 1'b0;
			cnt_q        <= '0;
			psc_q        <= '0;
			psc_act_q    <= '0;
			psc_cnt_q    <= '0;
			arr_q        <= '1;
			arr_act_q    <= '1;
			phase_down_q <= 1'b0;
		end else if (accept) begin
			cen_q        <= cen_d;
			urs_q        <= urs_d;
			opm_q        <= opm_d;
			dir_q        <= dir_d;
			cms_q        <= cms_d;
			arpe_q       <= arpe_d;
			dier_q       <= dier_d;
			uif_q        <= uif_d;
			cnt_q        <= cnt_d;
			psc_q        <= psc_d;
			psc_act_q    <= psc_act_d;
			psc_cnt_q    <= psc_cnt_d;
			arr_q        <= arr_d;
			arr_act_q    <= arr_act_d;
			phase_down_q <= phase_down_d;
		end
	end

	// result register, refilled in the cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q  <= rd_d;
			irq_q <= uif_d & dier_d[0];
			upd_q <= upd_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = rd_q;
	assign irq_level    = irq_q;
	assign update_event = upd_q;

	// a bus access never reports an update
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation != OP_TICK |=> !update_event)
		else $error("update event reported for a bus access");

	// only a read transfer returns data
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation != OP_READ |=> read_data == '0)
		else $error("read data nonzero on a non-read transfer");

	// a disabled counter cannot produce an update
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == OP_TICK && !cen_q |=> !update_event)
		else $error("update event while counter disabled");

	// an update always leaves the flag set
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && upd_d |=> uif_q)
		else $error("update flag not set after update");

endmodule
